### rtl/assert_macros.svh
// assertion helpers shared by the cell, tail and top-level rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ngcs_pkg.sv
`default_nettype none

package ngcs_pkg;

  localparam int LAT_W      = 27;
  localparam int BLAT_W     = 24;
  localparam int BLON_W     = 25;
  localparam int SPL_REG_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int NCORNER    = 4;
  localparam int DIFF_W     = 28;
  localparam int SQ_W       = 55;
  localparam int DIST_W     = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_LAT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_LAT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_LON      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_LON      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_LINE = 3'd4;

  typedef struct packed {
    logic vld;
    logic eoi;
    logic good;
    logic first_samp;
    logic first_line;
  } ngcs_ctl_t;

  typedef logic [NCORNER-1:0][DIST_W-1:0] dist_vec_t;

endpackage

`default_nettype wire

### rtl/ngcs_front.sv
`default_nettype none

module ngcs_front import ngcs_pkg::*; #(
  parameter int MAX_LINES   = 4096,
  parameter int MAX_SAMPLES = 2048,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [LAT_W-1:0]  in_point_lat,
  input  wire logic signed [LAT_W-1:0]  in_point_lon,
  input  wire logic                     in_end_of_image,
  input  wire logic signed [BLAT_W-1:0] box_min_lat,
  input  wire logic signed [BLAT_W-1:0] box_max_lat,
  input  wire logic signed [BLON_W-1:0] box_min_lon,
  input  wire logic signed [BLON_W-1:0] box_max_lon,
  input  wire logic [SPL_REG_W-1:0]     samples_per_line,
  output ngcs_ctl_t                     ctl_o,
  output logic [$clog2(MAX_LINES+1)-1:0]   line_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] samp_o,
  output logic signed [LAT_W-1:0]       lat_o,
  output logic signed [LAT_W-1:0]       lon_o,
  output dist_vec_t                     dist_o
);

  localparam int LINE_W    = $clog2(MAX_LINES+1);
  localparam int SAMPLE_W  = $clog2(MAX_SAMPLES+1);
  localparam int LPOS_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SPOS_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SPL_CMP_W = ((SAMPLE_W > SPL_REG_W) ? SAMPLE_W : SPL_REG_W) + 1;
  localparam longint DEG_ONE = longint'(1) << FRAC_BITS;
  localparam logic signed [31:0] LAT_FLOOR = 32'(-90 * DEG_ONE);
  localparam logic signed [31:0] LON_FLOOR = 32'(-180 * DEG_ONE);

  function automatic logic [SQ_W-1:0] square(input logic signed [DIFF_W-1:0] d);
    logic signed [2*DIFF_W-1:0] p;
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  logic [LPOS_W-1:0]    line_pos_r;
  logic [SPOS_W-1:0]    sample_pos_r;
  logic [SPL_CMP_W-1:0] spl_ext;
  logic [SPL_CMP_W-1:0] spl_eff;
  logic                 wrap;
  logic                 line_more;
  logic                 accept;
  logic                 good;

  ngcs_ctl_t                   s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [LINE_W-1:0]           s1_line_r, s2_line_r, s3_line_r, s4_line_r;
  logic [SAMPLE_W-1:0]         s1_samp_r, s2_samp_r, s3_samp_r, s4_samp_r;
  logic signed [LAT_W-1:0]     s1_lat_r, s2_lat_r, s3_lat_r, s4_lat_r;
  logic signed [LAT_W-1:0]     s1_lon_r, s2_lon_r, s3_lon_r, s4_lon_r;
  logic signed [DIFF_W-1:0]    dlat_hi_r, dlat_lo_r, dlon_lo_r, dlon_hi_r;
  logic [SQ_W-1:0]             sq_lat_hi_r, sq_lat_lo_r, sq_lon_lo_r, sq_lon_hi_r;
  dist_vec_t                   s4_dist_r;

  assign accept = in_valid && en;
  assign good   = !((32'(in_point_lat) < LAT_FLOOR) || (32'(in_point_lon) < LON_FLOOR));

  always_comb begin
    spl_ext = SPL_CMP_W'(samples_per_line);
    priority if (spl_ext == '0) begin
      spl_eff = SPL_CMP_W'(1);
    end else if (spl_ext > SPL_CMP_W'(MAX_SAMPLES)) begin
      spl_eff = SPL_CMP_W'(MAX_SAMPLES);
    end else begin
      spl_eff = spl_ext;
    end
  end

  assign wrap      = (SPL_CMP_W'(sample_pos_r) + SPL_CMP_W'(1)) >= spl_eff;
  assign line_more = ((LPOS_W+1)'(line_pos_r) + (LPOS_W+1)'(1)) < (LPOS_W+1)'(MAX_LINES);

  // raster position of the next point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r   <= '0;
      sample_pos_r <= '0;
    end else if (accept) begin
      priority if (in_end_of_image) begin
        line_pos_r   <= '0;
        sample_pos_r <= '0;
      end else if (wrap) begin
        sample_pos_r <= '0;
        if (line_more) begin
          line_pos_r <= line_pos_r + LPOS_W'(1);
        end
      end else begin
        sample_pos_r <= sample_pos_r + SPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r.vld        <= in_valid;
      s1_ctl_r.eoi        <= in_end_of_image;
      s1_ctl_r.good       <= good;
      s1_ctl_r.first_samp <= (sample_pos_r == '0);
      s1_ctl_r.first_line <= (line_pos_r == '0);
      s2_ctl_r            <= s1_ctl_r;
      s3_ctl_r            <= s2_ctl_r;
      s4_ctl_r            <= s3_ctl_r;
    end
  end

  // distance pipeline: difference, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      s1_line_r <= LINE_W'(line_pos_r) + LINE_W'(1);
      s1_samp_r <= SAMPLE_W'(sample_pos_r) + SAMPLE_W'(1);
      s1_lat_r  <= in_point_lat;
      s1_lon_r  <= in_point_lon;

      dlat_hi_r <= DIFF_W'(s1_lat_r) - DIFF_W'(box_max_lat);
      dlat_lo_r <= DIFF_W'(s1_lat_r) - DIFF_W'(box_min_lat);
      dlon_lo_r <= DIFF_W'(s1_lon_r) - DIFF_W'(box_min_lon);
      dlon_hi_r <= DIFF_W'(s1_lon_r) - DIFF_W'(box_max_lon);
      s2_line_r <= s1_line_r;
      s2_samp_r <= s1_samp_r;
      s2_lat_r  <= s1_lat_r;
      s2_lon_r  <= s1_lon_r;

      sq_lat_hi_r <= square(dlat_hi_r);
      sq_lat_lo_r <= square(dlat_lo_r);
      sq_lon_lo_r <= square(dlon_lo_r);
      sq_lon_hi_r <= square(dlon_hi_r);
      s3_line_r   <= s2_line_r;
      s3_samp_r   <= s2_samp_r;
      s3_lat_r    <= s2_lat_r;
      s3_lon_r    <= s2_lon_r;

      // corner order: upper left, upper right, lower left, lower right
      s4_dist_r[0] <= DIST_W'(sq_lat_hi_r) + DIST_W'(sq_lon_lo_r);
      s4_dist_r[1] <= DIST_W'(sq_lat_hi_r) + DIST_W'(sq_lon_hi_r);
      s4_dist_r[2] <= DIST_W'(sq_lat_lo_r) + DIST_W'(sq_lon_lo_r);
      s4_dist_r[3] <= DIST_W'(sq_lat_lo_r) + DIST_W'(sq_lon_hi_r);
      s4_line_r    <= s3_line_r;
      s4_samp_r    <= s3_samp_r;
      s4_lat_r     <= s3_lat_r;
      s4_lon_r     <= s3_lon_r;
    end
  end

  assign ctl_o  = s4_ctl_r;
  assign line_o = s4_line_r;
  assign samp_o = s4_samp_r;
  assign lat_o  = s4_lat_r;
  assign lon_o  = s4_lon_r;
  assign dist_o = s4_dist_r;

endmodule

`default_nettype wire

### rtl/ngcs_cell.sv
`default_nettype none

`include "assert_macros.svh"

module ngcs_cell import ngcs_pkg::*; #(
  parameter int LINE_W   = 13,
  parameter int SAMPLE_W = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire ngcs_ctl_t               ctl_i,
  input  wire logic [LINE_W-1:0]       line_i,
  input  wire logic [SAMPLE_W-1:0]     samp_i,
  input  wire logic signed [LAT_W-1:0] lat_i,
  input  wire logic signed [LAT_W-1:0] lon_i,
  input  wire dist_vec_t               dist_i,
  input  wire logic [LINE_W-1:0]       lmin_i,
  input  wire logic [LINE_W-1:0]       lmax_i,
  input  wire logic [SAMPLE_W-1:0]     smin_i,
  input  wire logic [SAMPLE_W-1:0]     smax_i,
  output ngcs_ctl_t                    ctl_o,
  output logic [LINE_W-1:0]            line_o,
  output logic [SAMPLE_W-1:0]          samp_o,
  output logic signed [LAT_W-1:0]      lat_o,
  output logic signed [LAT_W-1:0]      lon_o,
  output dist_vec_t                    dist_o,
  output logic [LINE_W-1:0]            lmin_o,
  output logic [LINE_W-1:0]            lmax_o,
  output logic [SAMPLE_W-1:0]          smin_o,
  output logic [SAMPLE_W-1:0]          smax_o
);

  logic [DIST_W-1:0]       best_dist_r;
  logic [LINE_W-1:0]       best_line_r;
  logic [SAMPLE_W-1:0]     best_sample_r;
  logic                    upd;
  logic [LINE_W-1:0]       bl;
  logic [SAMPLE_W-1:0]     bs;
  logic [LINE_W-1:0]       lmin_nxt, lmax_nxt;
  logic [SAMPLE_W-1:0]     smin_nxt, smax_nxt;

  ngcs_ctl_t               ctl_r;
  logic [LINE_W-1:0]       line_r, lmin_r, lmax_r;
  logic [SAMPLE_W-1:0]     samp_r, smin_r, smax_r;
  logic signed [LAT_W-1:0] lat_r, lon_r;
  dist_vec_t               dist_r;

  always_comb begin
    upd      = ctl_i.vld && ctl_i.good && (dist_i[0] < best_dist_r);
    bl       = upd ? line_i : best_line_r;
    bs       = upd ? samp_i : best_sample_r;
    lmin_nxt = (bl < lmin_i) ? bl : lmin_i;
    lmax_nxt = (bl > lmax_i) ? bl : lmax_i;
    smin_nxt = (bs < smin_i) ? bs : smin_i;
    smax_nxt = (bs > smax_i) ? bs : smax_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r         <= '0;
      best_dist_r   <= '1;
      best_line_r   <= '0;
      best_sample_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
      priority if (ctl_i.vld && ctl_i.eoi) begin
        best_dist_r   <= '1;
        best_line_r   <= '0;
        best_sample_r <= '0;
      end else if (upd) begin
        best_dist_r   <= dist_i[0];
        best_line_r   <= line_i;
        best_sample_r <= samp_i;
      end else begin
        best_dist_r   <= best_dist_r;
      end
    end
  end

  // next cell sees its own corner at position zero
  always_ff @(posedge clk) begin
    if (en) begin
      line_r <= line_i;
      samp_r <= samp_i;
      lat_r  <= lat_i;
      lon_r  <= lon_i;
      dist_r <= dist_i >> DIST_W;
      lmin_r <= lmin_nxt;
      lmax_r <= lmax_nxt;
      smin_r <= smin_nxt;
      smax_r <= smax_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign line_o = line_r;
  assign samp_o = samp_r;
  assign lat_o  = lat_r;
  assign lon_o  = lon_r;
  assign dist_o = dist_r;
  assign lmin_o = lmin_r;
  assign lmax_o = lmax_r;
  assign smin_o = smin_r;
  assign smax_o = smax_r;

  `ASSERT_RST(a_best_consistent, clk, rst_n, ((best_line_r == '0) == (best_dist_r == '1)) && ((best_sample_r == '0) == (best_line_r == '0)), "corner best line, sample and distance disagree")

endmodule

`default_nettype wire

### rtl/ngcs_tail.sv
`default_nettype none

`include "assert_macros.svh"

module ngcs_tail import ngcs_pkg::*; #(
  parameter int LINE_W    = 13,
  parameter int SAMPLE_W  = 12,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire ngcs_ctl_t               ctl_i,
  input  wire logic signed [LAT_W-1:0] lat_i,
  input  wire logic signed [LAT_W-1:0] lon_i,
  input  wire logic [LINE_W-1:0]       lmin_i,
  input  wire logic [LINE_W-1:0]       lmax_i,
  input  wire logic [SAMPLE_W-1:0]     smin_i,
  input  wire logic [SAMPLE_W-1:0]     smax_i,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic [LINE_W-1:0]            out_start_line,
  output logic [SAMPLE_W-1:0]          out_start_sample,
  output logic [LINE_W-1:0]            out_window_lines,
  output logic [SAMPLE_W-1:0]          out_window_samples,
  output logic                         out_not_in_image,
  output logic signed [LAT_W-1:0]      out_seen_min_lat,
  output logic signed [LAT_W-1:0]      out_seen_max_lat,
  output logic signed [LAT_W-1:0]      out_seen_min_lon,
  output logic signed [LAT_W-1:0]      out_seen_max_lon,
  output logic                         out_ascending
);

  localparam longint DEG_ONE = longint'(1) << FRAC_BITS;
  localparam logic signed [LAT_W-1:0] POS999 = LAT_W'(999 * DEG_ONE);
  localparam logic signed [LAT_W-1:0] NEG999 = LAT_W'(-999 * DEG_ONE);

  logic signed [LAT_W-1:0] bmin_lat_r, bmax_lat_r, bmin_lon_r, bmax_lon_r;
  logic signed [LAT_W-1:0] first_lat_r, last_lat_r;
  logic signed [LAT_W-1:0] bmin_lat_nxt, bmax_lat_nxt, bmin_lon_nxt, bmax_lon_nxt;
  logic signed [LAT_W-1:0] first_lat_nxt, last_lat_nxt;
  logic                    take;
  logic                    out_valid_r;

  logic [LINE_W-1:0]       start_line_r, window_lines_r;
  logic [SAMPLE_W-1:0]     start_sample_r, window_samples_r;
  logic                    not_in_image_r, ascending_r;
  logic signed [LAT_W-1:0] seen_min_lat_r, seen_max_lat_r, seen_min_lon_r, seen_max_lon_r;

  assign take = en && ctl_i.vld;

  always_comb begin
    bmin_lat_nxt  = (ctl_i.good && (lat_i < bmin_lat_r)) ? lat_i : bmin_lat_r;
    bmax_lat_nxt  = (ctl_i.good && (lat_i > bmax_lat_r)) ? lat_i : bmax_lat_r;
    bmin_lon_nxt  = (ctl_i.good && (lon_i < bmin_lon_r)) ? lon_i : bmin_lon_r;
    bmax_lon_nxt  = (ctl_i.good && (lon_i > bmax_lon_r)) ? lon_i : bmax_lon_r;
    first_lat_nxt = (ctl_i.first_samp && ctl_i.first_line) ? lat_i : first_lat_r;
    last_lat_nxt  = (ctl_i.first_samp && !ctl_i.first_line) ? lat_i : last_lat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bmin_lat_r  <= POS999;
      bmax_lat_r  <= NEG999;
      bmin_lon_r  <= POS999;
      bmax_lon_r  <= NEG999;
      first_lat_r <= '0;
      last_lat_r  <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (ctl_i.eoi) begin
          out_valid_r <= 1'b1;
          bmin_lat_r  <= POS999;
          bmax_lat_r  <= NEG999;
          bmin_lon_r  <= POS999;
          bmax_lon_r  <= NEG999;
          first_lat_r <= '0;
          last_lat_r  <= '0;
        end else begin
          bmin_lat_r  <= bmin_lat_nxt;
          bmax_lat_r  <= bmax_lat_nxt;
          bmin_lon_r  <= bmin_lon_nxt;
          bmax_lon_r  <= bmax_lon_nxt;
          first_lat_r <= first_lat_nxt;
          last_lat_r  <= last_lat_nxt;
        end
      end
    end
  end

  // result register, loaded by the end-of-image point
  always_ff @(posedge clk) begin
    if (take && ctl_i.eoi) begin
      start_line_r     <= lmin_i;
      start_sample_r   <= smin_i;
      window_lines_r   <= lmax_i - lmin_i + LINE_W'(1);
      window_samples_r <= smax_i - smin_i + SAMPLE_W'(1);
      not_in_image_r   <= (lmin_i == '0) || (smin_i == '0);
      seen_min_lat_r   <= bmin_lat_nxt;
      seen_max_lat_r   <= bmax_lat_nxt;
      seen_min_lon_r   <= bmin_lon_nxt;
      seen_max_lon_r   <= bmax_lon_nxt;
      ascending_r      <= last_lat_nxt > first_lat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_line     = start_line_r;
  assign out_start_sample   = start_sample_r;
  assign out_window_lines   = window_lines_r;
  assign out_window_samples = window_samples_r;
  assign out_not_in_image   = not_in_image_r;
  assign out_seen_min_lat   = seen_min_lat_r;
  assign out_seen_max_lat   = seen_max_lat_r;
  assign out_seen_min_lon   = seen_min_lon_r;
  assign out_seen_max_lon   = seen_max_lon_r;
  assign out_ascending      = ascending_r;

  `ASSERT_RST(a_result_from_eoi, clk, rst_n, $rose(out_valid_r) |-> $past(en && ctl_i.vld && ctl_i.eoi), "result appeared without an end-of-image point")
  `ASSERT_ANY(a_reset_clears_out, clk, !rst_n |=> !out_valid_r, "result valid survived reset")

endmodule

`default_nettype wire

### rtl/nearest_grid_corner_search.sv
`default_nettype none

// an end-of-image point reaches the result via the front, each corner cell and the tail
// one point per cycle unless stalled; the corner cells compare and update combinationally
// input stalls only while an end-of-image point reaches the result register and
// the previous result is still held by the downstream side
// synchronous reset loads the box and line length defaults and clears all scan state

`include "assert_macros.svh"

module nearest_grid_corner_search import ngcs_pkg::*; #(
  parameter int MAX_LINES   = 4096,
  parameter int MAX_SAMPLES = 2048,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [LAT_W-1:0]             in_point_lat,
  input  wire logic signed [LAT_W-1:0]             in_point_lon,
  input  wire logic                                in_end_of_image,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [$clog2(MAX_LINES+1)-1:0]           out_start_line,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]         out_start_sample,
  output logic [$clog2(MAX_LINES+1)-1:0]           out_window_lines,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]         out_window_samples,
  output logic                                     out_not_in_image,
  output logic signed [LAT_W-1:0]                  out_seen_min_lat,
  output logic signed [LAT_W-1:0]                  out_seen_max_lat,
  output logic signed [LAT_W-1:0]                  out_seen_min_lon,
  output logic signed [LAT_W-1:0]                  out_seen_max_lon,
  output logic                                     out_ascending,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]                cfg_index,
  input  wire logic [CFG_DATA_W-1:0]               cfg_data
);

  localparam int LINE_W   = $clog2(MAX_LINES+1);
  localparam int SAMPLE_W = $clog2(MAX_SAMPLES+1);
  localparam longint DEG_ONE = longint'(1) << FRAC_BITS;

  logic signed [BLAT_W-1:0] box_min_lat_r, box_max_lat_r;
  logic signed [BLON_W-1:0] box_min_lon_r, box_max_lon_r;
  logic [SPL_REG_W-1:0]     spl_r;
  logic                     pipe_en;

  ngcs_ctl_t               c_ctl  [NCORNER+1];
  logic [LINE_W-1:0]       c_line [NCORNER+1];
  logic [SAMPLE_W-1:0]     c_samp [NCORNER+1];
  logic signed [LAT_W-1:0] c_lat  [NCORNER+1];
  logic signed [LAT_W-1:0] c_lon  [NCORNER+1];
  dist_vec_t               c_dist [NCORNER+1];
  logic [LINE_W-1:0]       c_lmin [NCORNER+1];
  logic [LINE_W-1:0]       c_lmax [NCORNER+1];
  logic [SAMPLE_W-1:0]     c_smin [NCORNER+1];
  logic [SAMPLE_W-1:0]     c_smax [NCORNER+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_lat_r <= BLAT_W'(-90 * DEG_ONE);
      box_max_lat_r <= BLAT_W'(90 * DEG_ONE);
      box_min_lon_r <= BLON_W'(-180 * DEG_ONE);
      box_max_lon_r <= BLON_W'(180 * DEG_ONE);
      spl_r         <= SPL_REG_W'(1354);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_MIN_LAT:      box_min_lat_r <= cfg_data[BLAT_W-1:0];
        CFG_BOX_MAX_LAT:      box_max_lat_r <= cfg_data[BLAT_W-1:0];
        CFG_BOX_MIN_LON:      box_min_lon_r <= cfg_data[BLON_W-1:0];
        CFG_BOX_MAX_LON:      box_max_lon_r <= cfg_data[BLON_W-1:0];
        CFG_SAMPLES_PER_LINE: spl_r         <= cfg_data[SPL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // freeze only when a result would overwrite one still waiting
  assign pipe_en  = !(c_ctl[NCORNER].vld && c_ctl[NCORNER].eoi && out_valid && out_stall);
  assign in_stall = !pipe_en;

  ngcs_front #(
    .MAX_LINES   (MAX_LINES),
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (pipe_en),
    .in_valid         (in_valid),
    .in_point_lat     (in_point_lat),
    .in_point_lon     (in_point_lon),
    .in_end_of_image  (in_end_of_image),
    .box_min_lat      (box_min_lat_r),
    .box_max_lat      (box_max_lat_r),
    .box_min_lon      (box_min_lon_r),
    .box_max_lon      (box_max_lon_r),
    .samples_per_line (spl_r),
    .ctl_o            (c_ctl[0]),
    .line_o           (c_line[0]),
    .samp_o           (c_samp[0]),
    .lat_o            (c_lat[0]),
    .lon_o            (c_lon[0]),
    .dist_o           (c_dist[0])
  );

  assign c_lmin[0] = '1;
  assign c_lmax[0] = '0;
  assign c_smin[0] = '1;
  assign c_smax[0] = '0;

  for (genvar k = 0; k < NCORNER; k++) begin : g_cell
    ngcs_cell #(
      .LINE_W   (LINE_W),
      .SAMPLE_W (SAMPLE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (pipe_en),
      .ctl_i  (c_ctl[k]),
      .line_i (c_line[k]),
      .samp_i (c_samp[k]),
      .lat_i  (c_lat[k]),
      .lon_i  (c_lon[k]),
      .dist_i (c_dist[k]),
      .lmin_i (c_lmin[k]),
      .lmax_i (c_lmax[k]),
      .smin_i (c_smin[k]),
      .smax_i (c_smax[k]),
      .ctl_o  (c_ctl[k+1]),
      .line_o (c_line[k+1]),
      .samp_o (c_samp[k+1]),
      .lat_o  (c_lat[k+1]),
      .lon_o  (c_lon[k+1]),
      .dist_o (c_dist[k+1]),
      .lmin_o (c_lmin[k+1]),
      .lmax_o (c_lmax[k+1]),
      .smin_o (c_smin[k+1]),
      .smax_o (c_smax[k+1])
    );
  end

  ngcs_tail #(
    .LINE_W    (LINE_W),
    .SAMPLE_W  (SAMPLE_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_tail (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (pipe_en),
    .ctl_i              (c_ctl[NCORNER]),
    .lat_i              (c_lat[NCORNER]),
    .lon_i              (c_lon[NCORNER]),
    .lmin_i             (c_lmin[NCORNER]),
    .lmax_i             (c_lmax[NCORNER]),
    .smin_i             (c_smin[NCORNER]),
    .smax_i             (c_smax[NCORNER]),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_start_line     (out_start_line),
    .out_start_sample   (out_start_sample),
    .out_window_lines   (out_window_lines),
    .out_window_samples (out_window_samples),
    .out_not_in_image   (out_not_in_image),
    .out_seen_min_lat   (out_seen_min_lat),
    .out_seen_max_lat   (out_seen_max_lat),
    .out_seen_min_lon   (out_seen_min_lon),
    .out_seen_max_lon   (out_seen_max_lon),
    .out_ascending      (out_ascending)
  );

  `ASSERT_RST(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall && c_ctl[NCORNER].eoi), "input stalled without a blocked result")
  `ASSERT_RST(a_frozen_chain, clk, rst_n, !pipe_en |=> $stable(c_ctl[NCORNER]) && $stable(c_lmin[NCORNER]), "blocked end-of-image point moved")

endmodule

`default_nettype wire

### bench/tb.sv
module tb;
  import ngcs_pkg::*;

  localparam int LINE_W = 13;
  localparam int SAMP_W = 12;
  localparam int MAX_LINES = 4096;
  localparam int MAX_SAMPLES = 2048;
  localparam int DEG1 = 1 << 16;
  localparam int LAT_EDGE = 90 * DEG1;
  localparam int LON_EDGE = 180 * DEG1;
  localparam int FILL_DEG = 999 * DEG1;
  localparam int LAT_MAX = (1 << (LAT_W - 1)) - 1;
  localparam int LAT_MIN = -(1 << (LAT_W - 1));
  localparam int LATENCY = 8;
  localparam int SETTLE = LATENCY + 4;
  localparam longint FAR_DIST = (64'd1 << 58) - 1;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [LINE_W-1:0] start_line;
    logic [SAMP_W-1:0] start_sample;
    logic [LINE_W-1:0] window_lines;
    logic [SAMP_W-1:0] window_samples;
    logic              not_in_image;
    logic [LAT_W-1:0]  seen_min_lat;
    logic [LAT_W-1:0]  seen_max_lat;
    logic [LAT_W-1:0]  seen_min_lon;
    logic [LAT_W-1:0]  seen_max_lon;
    logic              ascending;
  } window_t;

  class window_scoreboard;
    logic signed [BLAT_W-1:0] lat_south, lat_north;
    logic signed [BLON_W-1:0] lon_west, lon_east;
    logic [SPL_REG_W-1:0] line_len;
    int unsigned line_idx, samp_idx;
    longint near_dist[NCORNER];
    int unsigned near_line[NCORNER], near_samp[NCORNER];
    logic signed [LAT_W-1:0] lat_lo, lat_hi, lon_lo, lon_hi, first_lat, later_lat;
    window_t due_windows[$];
    int fails;

    function new();
      lat_south = BLAT_W'(-LAT_EDGE);
      lat_north = BLAT_W'(LAT_EDGE);
      lon_west = BLON_W'(-LON_EDGE);
      lon_east = BLON_W'(LON_EDGE);
      line_len = SPL_REG_W'(1354);
      fails = 0;
      restart_scan();
    endfunction

    function void restart_scan();
      line_idx = 0;
      samp_idx = 0;
      for (int i = 0; i < NCORNER; i++) begin
        near_dist[i] = FAR_DIST;
        near_line[i] = 0;
        near_samp[i] = 0;
      end
      lat_lo = LAT_W'(FILL_DEG);
      lat_hi = LAT_W'(-FILL_DEG);
      lon_lo = LAT_W'(FILL_DEG);
      lon_hi = LAT_W'(-FILL_DEG);
      first_lat = '0;
      later_lat = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_BOX_MIN_LAT: lat_south = value[BLAT_W-1:0];
        CFG_BOX_MAX_LAT: lat_north = value[BLAT_W-1:0];
        CFG_BOX_MIN_LON: lon_west = value[BLON_W-1:0];
        CFG_BOX_MAX_LON: lon_east = value[BLON_W-1:0];
        CFG_SAMPLES_PER_LINE: line_len = value[SPL_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_windows.size();
    endfunction

    function void take_point(logic signed [LAT_W-1:0] lat, logic signed [LAT_W-1:0] lon,
                             logic eoi);
      int unsigned len;
      longint dlat, dlon, sqd;
      int unsigned lmin, lmax, smin, smax;
      window_t w;
      len = line_len;
      if (len == 0) len = 1;
      if (len > MAX_SAMPLES) len = MAX_SAMPLES;
      if (samp_idx == 0) begin
        if (line_idx == 0) first_lat = lat;
        else later_lat = lat;
      end
      if (lat >= -LAT_EDGE && lon >= -LON_EDGE) begin
        if (lat < lat_lo) lat_lo = lat;
        if (lat > lat_hi) lat_hi = lat;
        if (lon < lon_lo) lon_lo = lon;
        if (lon > lon_hi) lon_hi = lon;
        // corners in order upper left, upper right, lower left, lower right
        for (int i = 0; i < NCORNER; i++) begin
          dlat = lat - ((i < 2) ? lat_north : lat_south);
          dlon = lon - ((i == 0 || i == 2) ? lon_west : lon_east);
          sqd = dlat * dlat + dlon * dlon;
          if (sqd < near_dist[i]) begin
            near_dist[i] = sqd;
            near_line[i] = line_idx + 1;
            near_samp[i] = samp_idx + 1;
          end
        end
      end
      if (samp_idx + 1 >= len) begin
        samp_idx = 0;
        if (line_idx + 1 < MAX_LINES) line_idx++;
      end else begin
        samp_idx++;
      end
      if (!eoi) return;
      lmin = near_line[0];
      lmax = near_line[0];
      smin = near_samp[0];
      smax = near_samp[0];
      for (int i = 1; i < NCORNER; i++) begin
        if (near_line[i] < lmin) lmin = near_line[i];
        if (near_line[i] > lmax) lmax = near_line[i];
        if (near_samp[i] < smin) smin = near_samp[i];
        if (near_samp[i] > smax) smax = near_samp[i];
      end
      w.start_line = LINE_W'(lmin);
      w.start_sample = SAMP_W'(smin);
      w.window_lines = LINE_W'(lmax - lmin + 1);
      w.window_samples = SAMP_W'(smax - smin + 1);
      w.not_in_image = (lmin == 0 || smin == 0);
      w.seen_min_lat = lat_lo;
      w.seen_max_lat = lat_hi;
      w.seen_min_lon = lon_lo;
      w.seen_max_lon = lon_hi;
      w.ascending = (later_lat > first_lat);
      due_windows.push_back(w);
      restart_scan();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      fails++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_window(window_t got);
      window_t want;
      if (due_windows.size() == 0) begin
        report("result transfer with no window due");
        return;
      end
      want = due_windows.pop_front();
      cmp_field("start_line", got.start_line, want.start_line);
      cmp_field("start_sample", got.start_sample, want.start_sample);
      cmp_field("window_lines", got.window_lines, want.window_lines);
      cmp_field("window_samples", got.window_samples, want.window_samples);
      cmp_field("not_in_image", got.not_in_image, want.not_in_image);
      cmp_field("seen_min_lat", got.seen_min_lat, want.seen_min_lat);
      cmp_field("seen_max_lat", got.seen_max_lat, want.seen_max_lat);
      cmp_field("seen_min_lon", got.seen_min_lon, want.seen_min_lon);
      cmp_field("seen_max_lon", got.seen_max_lon, want.seen_max_lon);
      cmp_field("ascending", got.ascending, want.ascending);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [LAT_W-1:0] in_point_lat = '0;
  logic signed [LAT_W-1:0] in_point_lon = '0;
  logic in_end_of_image = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LINE_W-1:0] out_start_line;
  logic [SAMP_W-1:0] out_start_sample;
  logic [LINE_W-1:0] out_window_lines;
  logic [SAMP_W-1:0] out_window_samples;
  logic out_not_in_image;
  logic signed [LAT_W-1:0] out_seen_min_lat, out_seen_max_lat;
  logic signed [LAT_W-1:0] out_seen_min_lon, out_seen_max_lon;
  logic out_ascending;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BOX_MIN_LAT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  window_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  logic signed [LAT_W-1:0] prev_lat = '0, prev_lon = '0;

  nearest_grid_corner_search dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_point_lat(in_point_lat),
    .in_point_lon(in_point_lon),
    .in_end_of_image(in_end_of_image),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_start_line(out_start_line),
    .out_start_sample(out_start_sample),
    .out_window_lines(out_window_lines),
    .out_window_samples(out_window_samples),
    .out_not_in_image(out_not_in_image),
    .out_seen_min_lat(out_seen_min_lat),
    .out_seen_max_lat(out_seen_max_lat),
    .out_seen_min_lon(out_seen_min_lon),
    .out_seen_max_lon(out_seen_max_lon),
    .out_ascending(out_ascending),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // receiver: long hold on request, else random stall
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_window(window_t'{out_start_line, out_start_sample, out_window_lines,
                                out_window_samples, out_not_in_image, out_seen_min_lat,
                                out_seen_max_lat, out_seen_min_lon, out_seen_max_lon,
                                out_ascending});
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 70;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 70;
      end
      IDLE_BOTH: begin
        send_idle_pct = 14;
        recv_stall_pct = 14;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic program_box(input int south, input int north, input int west,
                             input int east, input int len);
    write_reg(CFG_BOX_MIN_LAT, south);
    write_reg(CFG_BOX_MAX_LAT, north);
    write_reg(CFG_BOX_MIN_LON, west);
    write_reg(CFG_BOX_MAX_LON, east);
    write_reg(CFG_SAMPLES_PER_LINE, len);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_point(input logic signed [LAT_W-1:0] lat,
                            input logic signed [LAT_W-1:0] lon, input logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_lat <= lat;
    in_point_lon <= lon;
    in_end_of_image <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_point(lat, lon, eoi);
  endtask

  task automatic pick_point(output logic signed [LAT_W-1:0] lat,
                            output logic signed [LAT_W-1:0] lon);
    int c;
    c = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0: begin
        lat = LAT_W'($urandom);
        lon = LAT_W'($urandom);
      end
      1: begin
        lat = LAT_W'(-FILL_DEG);
        lon = LAT_W'(-FILL_DEG);
      end
      2: begin
        lat = prev_lat;
        lon = prev_lon;
      end
      3, 4: begin
        lat = LAT_W'(int'(c[1] ? sb.lat_south : sb.lat_north)
                     + int'($urandom_range(0, 2000)) - 1000);
        lon = LAT_W'(int'(c[0] ? sb.lon_east : sb.lon_west)
                     + int'($urandom_range(0, 2000)) - 1000);
      end
      default: begin
        lat = LAT_W'(int'($urandom_range(0, 2 * LAT_EDGE)) - LAT_EDGE);
        lon = LAT_W'(int'($urandom_range(0, 2 * LON_EDGE)) - LON_EDGE);
      end
    endcase
    prev_lat = lat;
    prev_lon = lon;
  endtask

  task automatic send_image(input int n_points);
    logic signed [LAT_W-1:0] lat, lon;
    for (int k = 0; k < n_points; k++) begin
      pick_point(lat, lon);
      send_point(lat, lon, k == n_points - 1);
    end
  endtask

  initial begin
    #1000000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic signed [LAT_W-1:0] lat, lon;
    int sent, n;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_box(-DEG1, DEG1, -2 * DEG1, 2 * DEG1, 3);
    // invalid sample 0, exact corner hits and a tie, edge and extreme values
    send_point(-LAT_EDGE - 1, 0, 1'b0);
    send_point(DEG1, -2 * DEG1, 1'b0);
    send_point(DEG1, -2 * DEG1, 1'b0);
    send_point(-LAT_EDGE, -LON_EDGE, 1'b0);
    send_point(0, -LON_EDGE - 1, 1'b0);
    send_point(LAT_MAX, LAT_MAX, 1'b0);
    send_point(LAT_MIN, LAT_MIN, 1'b0);
    send_point(-DEG1, 2 * DEG1, 1'b0);
    send_point(-DEG1, -2 * DEG1, 1'b1);
    // nothing valid
    send_point(-FILL_DEG, -FILL_DEG, 1'b0);
    send_point(0, LAT_MIN, 1'b1);
    // single line
    send_point(-2 * DEG1, 0, 1'b1);
    // line shortened below the current sample
    send_point(DEG1, DEG1, 1'b0);
    send_point(-DEG1, 0, 1'b0);
    wait_idle(SETTLE);
    write_reg(CFG_SAMPLES_PER_LINE, 2);
    cfg_valid <= 1'b0;
    send_point(5 * DEG1, 0, 1'b0);
    send_point(0, 3 * DEG1, 1'b0);
    send_point(-5 * DEG1, 0, 1'b1);

    // zero line length
    wait_idle(SETTLE);
    program_box(-LAT_EDGE, LAT_EDGE, -LON_EDGE, LON_EDGE, 0);
    for (int k = 0; k < 20; k++) begin
      pick_point(lat, lon);
      send_point(lat, lon, 1'b0);
    end
    send_point(LAT_EDGE, -LON_EDGE, 1'b1);

    for (int p = 0; p < 8; p++) begin
      wait_idle(SETTLE);
      case (p)
        0: program_box(-LAT_EDGE, LAT_EDGE, -LON_EDGE, LON_EDGE, 1354);
        1: program_box(LAT_EDGE, LAT_EDGE, LON_EDGE, LON_EDGE, 1);
        2: program_box(-LAT_EDGE, -LAT_EDGE, -LON_EDGE, -LON_EDGE, MAX_SAMPLES);
        3: program_box(LAT_EDGE, -LAT_EDGE, LON_EDGE, -LON_EDGE, 4095);
        default: program_box(int'($urandom_range(0, 2 * LAT_EDGE)) - LAT_EDGE,
                             int'($urandom_range(0, 2 * LAT_EDGE)) - LAT_EDGE,
                             int'($urandom_range(0, 2 * LON_EDGE)) - LON_EDGE,
                             int'($urandom_range(0, 2 * LON_EDGE)) - LON_EDGE,
                             $urandom_range(1, 8));
      endcase
      set_idling(idle_mode_e'(p % 4));
      if (p == 4) begin
        // back up the result side, then let it drain completely
        hold_req = 400;
        repeat (30) send_image($urandom_range(1, 2));
        wait_idle(0);
      end
      sent = 0;
      while (sent < 45) begin
        n = $urandom_range(1, 24);
        send_image(n);
        sent += n;
      end
    end

    wait_idle(4 * LATENCY);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
